[sv/scis_pkg.sv]
`default_nettype none

package scis_pkg;

	// Input commands.
	localparam logic [2:0] CMD_WR_VEL = 3'd0;
	localparam logic [2:0] CMD_WR_INR = 3'd1;
	localparam logic [2:0] CMD_WR_ROW = 3'd2;
	localparam logic [2:0] CMD_SOLVE  = 3'd3;
	localparam logic [2:0] CMD_WARM   = 3'd4;
	localparam logic [2:0] CMD_RD_VEL = 3'd5;
	localparam logic [2:0] CMD_RD_ROW = 3'd6;

	// Record sizes in words.
	localparam int VEL_WORDS = 6;
	localparam int INR_WORDS = 9;
	localparam int ROW_WORDS = 21;

	// Row word positions.
	localparam logic [4:0] W_BODY_A = 5'd0;
	localparam logic [4:0] W_BODY_B = 5'd1;
	localparam logic [4:0] W_INVM_A = 5'd2;
	localparam logic [4:0] W_LIN_A  = 5'd4;
	localparam logic [4:0] W_ANG_A  = 5'd7;
	localparam logic [4:0] W_EFFM   = 5'd16;
	localparam logic [4:0] W_ERR    = 5'd17;
	localparam logic [4:0] W_LOWER  = 5'd18;
	localparam logic [4:0] W_UPPER  = 5'd19;
	localparam logic [4:0] W_IMP    = 5'd20;

	// Micro-operations executed at the end of each sequencer step.
	localparam logic [3:0] OP_NOP  = 4'd0;
	localparam logic [3:0] OP_LDA  = 4'd1;
	localparam logic [3:0] OP_LDB  = 4'd2;
	localparam logic [3:0] OP_LDI  = 4'd3;
	localparam logic [3:0] OP_MAC  = 4'd4;
	localparam logic [3:0] OP_BIAS = 4'd5;
	localparam logic [3:0] OP_MASS = 4'd6;
	localparam logic [3:0] OP_L1   = 4'd7;
	localparam logic [3:0] OP_L2   = 4'd8;
	localparam logic [3:0] OP_CLO  = 4'd9;
	localparam logic [3:0] OP_CHI  = 4'd10;
	localparam logic [3:0] OP_WIMP = 4'd11;
	localparam logic [3:0] OP_K    = 4'd12;
	localparam logic [3:0] OP_VW   = 4'd13;
	localparam logic [3:0] OP_G    = 4'd14;
	localparam logic [3:0] OP_WW   = 4'd15;

	// Multiplier operand selects.
	localparam logic [1:0] XS_ROW = 2'd0;
	localparam logic [1:0] XS_INR = 2'd1;
	localparam logic [1:0] XS_M   = 2'd2;
	localparam logic [1:0] XS_IS  = 2'd3;

	localparam logic [2:0] YS_VEL = 3'd0;
	localparam logic [2:0] YS_BR  = 3'd1;
	localparam logic [2:0] YS_MS  = 3'd2;
	localparam logic [2:0] YS_S   = 3'd3;
	localparam logic [2:0] YS_IMP = 3'd4;
	localparam logic [2:0] YS_D   = 3'd5;
	localparam logic [2:0] YS_K   = 3'd6;
	localparam logic [2:0] YS_G   = 3'd7;

	// Program counter landmarks.
	localparam logic [5:0] PC_LDI   = 6'd2;
	localparam logic [5:0] PC_APPLY = 6'd22;
	localparam logic [5:0] PC_LAST  = 6'd59;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] xsel;
		logic [2:0] ysel;
		logic [4:0] rword;
		logic       side;
		logic [2:0] vword;
		logic [3:0] iword;
		logic [1:0] gsel;
	} step_t;

	typedef struct packed {
		logic  latch;
		logic  prog;
		logic  exec;
		logic  load_out;
		step_t st;
	} dp_cmd_t;

	typedef struct packed {
		logic prog_cmd;
		logic warm;
		logic bodies_ok;
	} dp_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (x < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	// Step table of the solve and warm start programs.
	function automatic step_t step_desc(input logic [5:0] pc);
		step_t d;
		logic [3:0] t;
		logic [4:0] u;
		logic [3:0] r;
		logic [1:0] i;
		logic [1:0] q;
		d = '0;
		d.op = OP_NOP;
		t = '0;
		u = '0;
		r = '0;
		i = '0;
		q = '0;
		if (pc == 6'd0) begin
			d.op = OP_LDA;
			d.rword = W_BODY_A;
		end else if (pc == 6'd1) begin
			d.op = OP_LDB;
			d.rword = W_BODY_B;
		end else if (pc == 6'd2) begin
			d.op = OP_LDI;
			d.rword = W_IMP;
		end else if (pc <= 6'd14) begin
			t = 4'(pc - 6'd3);
			d.op = OP_MAC;
			d.xsel = XS_ROW;
			d.ysel = YS_VEL;
			d.rword = W_LIN_A + 5'(t);
			d.side = (t >= 4'd6);
			d.vword = (t >= 4'd6) ? 3'(t - 4'd6) : 3'(t);
		end else if (pc == 6'd15) begin
			d.op = OP_BIAS;
			d.xsel = XS_ROW;
			d.ysel = YS_BR;
			d.rword = W_ERR;
		end else if (pc == 6'd16) begin
			d.op = OP_MASS;
			d.xsel = XS_ROW;
			d.ysel = YS_MS;
			d.rword = W_EFFM;
		end else if (pc == 6'd17) begin
			d.op = OP_L1;
			d.xsel = XS_M;
			d.ysel = YS_S;
		end else if (pc == 6'd18) begin
			d.op = OP_L2;
			d.xsel = XS_IS;
			d.ysel = YS_IMP;
		end else if (pc == 6'd19) begin
			d.op = OP_CLO;
			d.rword = W_LOWER;
		end else if (pc == 6'd20) begin
			d.op = OP_CHI;
			d.rword = W_UPPER;
		end else if (pc == 6'd21) begin
			d.op = OP_WIMP;
			d.rword = W_IMP;
		end else begin
			d.side = (pc >= 6'd41);
			u = d.side ? 5'(pc - 6'd41) : 5'(pc - 6'd22);
			if (u == 5'd0) begin
				d.op = OP_K;
				d.xsel = XS_ROW;
				d.ysel = YS_D;
				d.rword = W_INVM_A + 5'(d.side);
			end else if (u <= 5'd3) begin
				d.op = OP_VW;
				d.xsel = XS_ROW;
				d.ysel = YS_K;
				d.rword = W_LIN_A + (d.side ? 5'd6 : 5'd0) + 5'(u - 5'd1);
				d.vword = 3'(u - 5'd1);
			end else if (u <= 5'd6) begin
				d.op = OP_G;
				d.xsel = XS_ROW;
				d.ysel = YS_D;
				d.rword = W_ANG_A + (d.side ? 5'd6 : 5'd0) + 5'(u - 5'd4);
				d.gsel = 2'(u - 5'd4);
			end else begin
				r = 4'(u - 5'd7);
				i = r[3:2];
				q = r[1:0];
				if (q != 2'd3) begin
					d.op = OP_MAC;
					d.xsel = XS_INR;
					d.ysel = YS_G;
					d.gsel = q;
					d.iword = 4'(i) * 4'd3 + 4'(q);
				end else begin
					d.op = OP_WW;
					d.vword = 3'd3 + 3'(i);
				end
			end
		end
		return d;
	endfunction

endpackage

`default_nettype wire

[sv/scis_ram.sv]
`default_nettype none

module scis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0]                         wdata,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single port, read before write.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

[sv/scis_ctrl.sv]
`default_nettype none

module scis_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire scis_pkg::dp_sts_t sts,
	output scis_pkg::dp_cmd_t      ctl
);

	import scis_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DEC   = 3'd1;
	localparam logic [2:0] S_RA    = 3'd2;
	localparam logic [2:0] S_RB    = 3'd3;
	localparam logic [2:0] S_ISSUE = 3'd4;
	localparam logic [2:0] S_MUL   = 3'd5;
	localparam logic [2:0] S_EXEC  = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	logic [2:0] state_q, state_d;
	logic [5:0] pc_q, pc_d;
	logic       out_valid_q;

	always_comb begin
		ctl.latch    = (state_q == S_IDLE) && in_valid;
		ctl.prog     = (state_q == S_ISSUE) || (state_q == S_MUL) || (state_q == S_EXEC);
		ctl.exec     = (state_q == S_RB) || (state_q == S_EXEC);
		ctl.load_out = (state_q == S_FIN) && (!out_valid_q || !out_stall);
		ctl.st       = step_desc(pc_q);
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		pc_d = pc_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.prog_cmd) begin
					pc_d = '0;
					state_d = S_ISSUE;
				end else begin
					state_d = S_RA;
				end
			end
			S_RA:    state_d = S_RB;
			S_RB:    state_d = S_FIN;
			S_ISSUE: state_d = S_MUL;
			S_MUL:   state_d = S_EXEC;
			S_EXEC: begin
				if (pc_q == PC_LDI && !sts.bodies_ok) begin
					state_d = S_FIN;
				end else if (pc_q == PC_LDI && sts.warm) begin
					pc_d = PC_APPLY;
					state_d = S_ISSUE;
				end else if (pc_q == PC_LAST) begin
					state_d = S_FIN;
				end else begin
					pc_d = pc_q + 6'd1;
					state_d = S_ISSUE;
				end
			end
			S_FIN: begin
				if (ctl.load_out) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q <= pc_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= PC_LAST)
		else $error("program counter beyond last step");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten while stalled");

	a_accept_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DEC))
		else $error("accepted beat not decoded");

	a_warm_jump: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && pc_q == PC_LDI && sts.warm && sts.bodies_ok)
		|=> (pc_q == PC_APPLY))
		else $error("warm start did not jump to apply");

endmodule

`default_nettype wire

[sv/scis_dp.sv]
`default_nettype none

module scis_dp #(
	parameter int MAX_BODIES = 64,
	parameter int MAX_ROWS   = 256
) (
	input  wire logic               clk,
	input  wire logic [2:0]         cmd,
	input  wire logic [7:0]         index,
	input  wire logic [4:0]         word_select,
	input  wire logic signed [31:0] value,
	input  wire logic [30:0]        bias_rate,
	input  wire logic [16:0]        mass_scale,
	input  wire logic [16:0]        impulse_scale,
	input  wire scis_pkg::dp_cmd_t  ctl,
	output scis_pkg::dp_sts_t       sts,
	output logic signed [31:0]      data
);

	import scis_pkg::*;

	localparam int BW      = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
	localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int VEL_D   = MAX_BODIES * VEL_WORDS;
	localparam int INR_D   = MAX_BODIES * INR_WORDS;
	localparam int ROW_D   = MAX_ROWS * ROW_WORDS;
	localparam int VAW     = $clog2(VEL_D);
	localparam int IAW     = $clog2(INR_D);
	localparam int RAW     = $clog2(ROW_D);

	logic [2:0]         cmd_q;
	logic [7:0]         idx_q;
	logic [4:0]         ws_q;
	logic signed [31:0] val_q;

	logic signed [31:0] ba_q, bb_q, imp_q, d_q, s_q, m_q, k_q, nw_q, res_q, data_q;
	logic signed [31:0] g_q [3];
	logic signed [55:0] acc_q;
	logic signed [47:0] prod_s1;

	logic               row_ok, body_idx_ok;
	logic [BW-1:0]      body_sel;
	logic [2:0]         vword;
	logic [3:0]         iword;
	logic [4:0]         rword;
	logic [VAW-1:0]     vel_addr;
	logic [IAW-1:0]     inr_addr;
	logic [RAW-1:0]     row_addr;
	logic               vel_we, inr_we, row_we;
	logic signed [31:0] vel_wdata, row_wdata;
	logic signed [31:0] vel_rd, inr_rd, row_rd;
	logic signed [31:0] xop, yop, gsel_val, lam, nw_raw;
	logic signed [63:0] prod_full;
	step_t              st;
	logic               simple_exec, step_exec;

	assign st = ctl.st;
	assign simple_exec = ctl.exec && !ctl.prog;
	assign step_exec = ctl.exec && ctl.prog;

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= cmd;
			idx_q <= index;
			ws_q <= word_select;
			val_q <= value;
		end
	end

	assign row_ok = {1'b0, idx_q} < 9'(MAX_ROWS);
	assign body_idx_ok = {1'b0, idx_q} < 9'(MAX_BODIES);

	always_comb begin
		sts.prog_cmd = ((cmd_q == CMD_SOLVE) || (cmd_q == CMD_WARM)) && row_ok;
		sts.warm = (cmd_q == CMD_WARM);
		sts.bodies_ok = (ba_q < 32'(MAX_BODIES)) && (bb_q < 32'(MAX_BODIES))
			&& !ba_q[31] && !bb_q[31];
	end

	// Memory addressing: step fields during a program, the beat's fields otherwise.
	always_comb begin
		if (ctl.prog) begin
			body_sel = st.side ? bb_q[BW-1:0] : ba_q[BW-1:0];
			vword = st.vword;
			iword = st.iword;
			rword = st.rword;
		end else begin
			body_sel = idx_q[BW-1:0];
			vword = ws_q[2:0];
			iword = ws_q[3:0];
			rword = ws_q;
		end
		vel_addr = VAW'(body_sel) * VAW'(VEL_WORDS) + VAW'(vword);
		inr_addr = IAW'(body_sel) * IAW'(INR_WORDS) + IAW'(iword);
		row_addr = RAW'(idx_q[RW-1:0]) * RAW'(ROW_WORDS) + RAW'(rword);
	end

	always_comb begin
		vel_we = 1'b0;
		inr_we = 1'b0;
		row_we = 1'b0;
		vel_wdata = val_q;
		row_wdata = val_q;
		if (simple_exec) begin
			vel_we = (cmd_q == CMD_WR_VEL) && body_idx_ok && (ws_q < 5'(VEL_WORDS));
			inr_we = (cmd_q == CMD_WR_INR) && body_idx_ok && (ws_q < 5'(INR_WORDS));
			row_we = (cmd_q == CMD_WR_ROW) && row_ok && (ws_q < 5'(ROW_WORDS));
		end else if (step_exec) begin
			vel_we = (st.op == OP_VW) || (st.op == OP_WW);
			row_we = (st.op == OP_WIMP);
			row_wdata = nw_q;
			if (st.op == OP_VW) begin
				vel_wdata = sat32(64'(vel_rd) + 64'(prod_s1));
			end else begin
				vel_wdata = sat32(64'(vel_rd) + 64'(sat32(64'(acc_q))));
			end
		end
	end

	scis_ram #(.WIDTH(32), .DEPTH(VEL_D)) u_vel (
		.clk(clk), .we(vel_we), .addr(vel_addr), .wdata(vel_wdata), .rdata(vel_rd)
	);
	scis_ram #(.WIDTH(32), .DEPTH(INR_D)) u_inr (
		.clk(clk), .we(inr_we), .addr(inr_addr), .wdata(val_q), .rdata(inr_rd)
	);
	scis_ram #(.WIDTH(32), .DEPTH(ROW_D)) u_row (
		.clk(clk), .we(row_we), .addr(row_addr), .wdata(row_wdata), .rdata(row_rd)
	);

	// Shared rounding multiplier with a registered product.
	always_comb begin
		case (st.gsel)
			2'd0:    gsel_val = g_q[0];
			2'd1:    gsel_val = g_q[1];
			default: gsel_val = g_q[2];
		endcase
		case (st.xsel)
			XS_ROW:  xop = row_rd;
			XS_INR:  xop = inr_rd;
			XS_M:    xop = m_q;
			default: xop = signed'(32'(impulse_scale));
		endcase
		case (st.ysel)
			YS_VEL:  yop = vel_rd;
			YS_BR:   yop = signed'(32'(bias_rate));
			YS_MS:   yop = signed'(32'(mass_scale));
			YS_S:    yop = s_q;
			YS_IMP:  yop = imp_q;
			YS_D:    yop = d_q;
			YS_K:    yop = k_q;
			default: yop = gsel_val;
		endcase
	end

	assign prod_full = 64'(xop) * 64'(yop);

	always_ff @(posedge clk) begin
		prod_s1 <= 48'((prod_full + 64'sd32768) >>> 16);
	end

	assign lam = sat32(64'(acc_q) - 64'(prod_s1));
	assign nw_raw = sat32(64'(imp_q) + 64'(lam));

	always_ff @(posedge clk) begin
		if (simple_exec) begin
			case (cmd_q)
				CMD_RD_VEL:
					res_q <= (body_idx_ok && ws_q < 5'(VEL_WORDS)) ? vel_rd : '0;
				CMD_RD_ROW:
					res_q <= (row_ok && ws_q < 5'(ROW_WORDS)) ? row_rd : '0;
				default: res_q <= '0;
			endcase
		end
		if (step_exec) begin
			case (st.op)
				OP_LDA: ba_q <= row_rd;
				OP_LDB: bb_q <= row_rd;
				OP_LDI: begin
					imp_q <= row_rd;
					d_q <= row_rd;
					acc_q <= '0;
					res_q <= (cmd_q == CMD_SOLVE) ? row_rd : '0;
				end
				OP_MAC:  acc_q <= acc_q + 56'(prod_s1);
				OP_BIAS: s_q <= sat32(64'(sat32(64'(acc_q))) + 64'(sat32(64'(prod_s1))));
				OP_MASS: m_q <= sat32(64'(prod_s1));
				OP_L1:   acc_q <= -56'(prod_s1);
				OP_L2:   nw_q <= nw_raw;
				OP_CLO: begin
					if (nw_q < row_rd) begin
						nw_q <= row_rd;
					end
				end
				OP_CHI: begin
					if (nw_q > row_rd) begin
						nw_q <= row_rd;
					end
				end
				OP_WIMP: begin
					d_q <= sat32(64'(nw_q) - 64'(imp_q));
					res_q <= nw_q;
				end
				OP_K: k_q <= sat32(64'(prod_s1));
				OP_G: begin
					g_q[st.gsel] <= sat32(64'(prod_s1));
					acc_q <= '0;
				end
				OP_WW: acc_q <= '0;
				default: ;
			endcase
		end
		if (ctl.load_out) begin
			data_q <= res_q;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

[sv/soft_constraint_impulse_solver_top.sv]
// Soft constraint sequential impulse solver, Q16.16 fixed point.
// Input beats carry cmd, index, word_select and value; an input beat is taken
// when in_valid is high and in_stall is low. Every input beat yields exactly
// one output beat on data, taken when out_valid is high and out_stall is low.
// Write commands load the velocity, inverse inertia and row memories one word
// at a time; read commands return a stored word, or zero when out of range;
// solve returns the new accumulated impulse, or the stored one for a row whose
// body index is out of range; everything else returns zero. Writes, reads and
// rejected commands pass through decode, a memory read, execute and the output
// register. A solve runs a 60-step program and a warm start a 41-step program;
// each step has a memory read, a pass through the shared 32x32 multiplier and
// an execute phase. A row whose body index is out of range stops after three
// steps. The single-port memories and the one shared multiplier set this step
// structure. One item is worked on at a time, so the next beat is taken at the
// earliest at the edge where the previous result can be taken; a new beat is
// taken once the previous item has handed its result to the output register,
// even while that result still waits on a stalled receiver. Reset clears the
// controller and the configuration registers (mass_scale to one); the memories
// hold no defined contents until written.
// Configuration is written over the APB port at byte addresses 0, 4 and 8.
`default_nettype none

module soft_constraint_impulse_solver_top #(
	parameter int MAX_BODIES = 64,
	parameter int MAX_ROWS   = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         cmd,
	input  wire logic [7:0]         index,
	input  wire logic [4:0]         word_select,
	input  wire logic signed [31:0] value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      data,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	import scis_pkg::*;

	// Register indexes within the APB window.
	localparam logic [1:0] REG_BIAS_RATE     = 2'd0;
	localparam logic [1:0] REG_MASS_SCALE    = 2'd1;
	localparam logic [1:0] REG_IMPULSE_SCALE = 2'd2;

	logic [30:0] bias_rate_q;
	logic [16:0] mass_scale_q;
	logic [16:0] impulse_scale_q;
	logic        cfg_wr;
	dp_cmd_t     ctl;
	dp_sts_t     sts;

	// The port never inserts wait states.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_rate_q <= '0;
			mass_scale_q <= 17'd65536;
			impulse_scale_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_BIAS_RATE:     bias_rate_q <= pwdata[30:0];
				REG_MASS_SCALE:    mass_scale_q <= pwdata[16:0];
				REG_IMPULSE_SCALE: impulse_scale_q <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_BIAS_RATE:     prdata = 32'(bias_rate_q);
			REG_MASS_SCALE:    prdata = 32'(mass_scale_q);
			REG_IMPULSE_SCALE: prdata = 32'(impulse_scale_q);
			default:           prdata = '0;
		endcase
	end

	// The controller sequences each item and owns both handshakes.
	scis_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts(sts),
		.ctl(ctl)
	);

	// The datapath holds the memories, the multiplier and the solver registers.
	scis_dp #(
		.MAX_BODIES(MAX_BODIES),
		.MAX_ROWS(MAX_ROWS)
	) u_dp (
		.clk(clk),
		.cmd(cmd),
		.index(index),
		.word_select(word_select),
		.value(value),
		.bias_rate(bias_rate_q),
		.mass_scale(mass_scale_q),
		.impulse_scale(impulse_scale_q),
		.ctl(ctl),
		.sts(sts),
		.data(data)
	);

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
	import scis_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Row word positions for side B, plus the unused command code.
	localparam logic [4:0] W_INVM_B = 5'd3;
	localparam logic [4:0] W_LIN_B  = 5'd10;
	localparam logic [4:0] W_ANG_B  = 5'd13;
	localparam logic [2:0] CMD_NONE = 3'd7;

	// Configuration register byte addresses.
	localparam logic [3:0] REG_BIAS_RATE     = 4'd0;
	localparam logic [3:0] REG_MASS_SCALE    = 4'd4;
	localparam logic [3:0] REG_IMPULSE_SCALE = 4'd8;

	localparam int NBODY = 64;
	localparam int NROW  = 256;

	typedef struct {
		logic [2:0]         cmd;
		logic [7:0]         idx;
		logic [4:0]         ws;
		logic signed [31:0] val;
	} beat_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [2:0] cmd;
	logic [7:0] index;
	logic [4:0] word_select;
	logic signed [31:0] value;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	soft_constraint_impulse_solver_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .index(index), .word_select(word_select), .value(value),
		.out_valid(out_valid), .out_stall(out_stall), .data(data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Beats waiting to be driven, and impulses or words the block should return.
	beat_t pending[$];
	logic signed [31:0] expected_data[$];
	beat_t cur;

	bit no_idle;
	int errors;
	int beats_taken;
	int solves_taken;
	int results_seen;

	// Shadow copy of the block's memories and configuration.
	logic signed [31:0] vel_m[NBODY*VEL_WORDS];
	logic signed [31:0] inr_m[NBODY*INR_WORDS];
	logic signed [31:0] row_m[NROW*ROW_WORDS];
	longint bias_q;
	longint mscale_q;
	longint iscale_q;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint sat(input longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// Q16.16 product rounded half up; the shift floors.
	function automatic longint mulq(input longint a, input longint b);
		return (a * b + 32768) >>> 16;
	endfunction

	task automatic push_body(input int body, input int rb, input int lin, input int ang,
			input longint invm, input longint amount);
		longint k;
		longint acc;
		longint g[3];
		k = sat(mulq(invm, amount));
		for (int i = 0; i < 3; i++) begin
			vel_m[body*VEL_WORDS+i] = 32'(sat(vel_m[body*VEL_WORDS+i]
				+ mulq(row_m[rb+lin+i], k)));
			g[i] = sat(mulq(row_m[rb+ang+i], amount));
		end
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += mulq(inr_m[body*INR_WORDS+i*3+j], g[j]);
			vel_m[body*VEL_WORDS+3+i] = 32'(sat(vel_m[body*VEL_WORDS+3+i] + sat(acc)));
		end
	endtask

	task automatic push_row(input int rb, input int a, input int b, input longint amount);
		push_body(a, rb, W_LIN_A, W_ANG_A, row_m[rb+W_INVM_A], amount);
		push_body(b, rb, W_LIN_B, W_ANG_B, row_m[rb+W_INVM_B], amount);
	endtask

	function automatic longint row_dot(input int rb, input int lin, input int ang,
			input int body);
		longint acc;
		acc = 0;
		for (int i = 0; i < 3; i++) begin
			acc += mulq(row_m[rb+lin+i], vel_m[body*VEL_WORDS+i]);
			acc += mulq(row_m[rb+ang+i], vel_m[body*VEL_WORDS+3+i]);
		end
		return acc;
	endfunction

	// Works out the returned word for one beat and updates the shadow state.
	task automatic predict_beat(input beat_t it, output logic signed [31:0] res);
		int rb;
		int a;
		int b;
		bit ok;
		longint old;
		longint jv;
		longint bias;
		longint m;
		longint s;
		longint lambda;
		longint nw;
		res = '0;
		rb = int'(it.idx) * ROW_WORDS;
		case (it.cmd)
			CMD_WR_VEL: if (it.idx < NBODY && it.ws < VEL_WORDS)
				vel_m[it.idx*VEL_WORDS+it.ws] = it.val;
			CMD_WR_INR: if (it.idx < NBODY && it.ws < INR_WORDS)
				inr_m[it.idx*INR_WORDS+it.ws] = it.val;
			CMD_WR_ROW: if (it.ws < ROW_WORDS)
				row_m[rb+it.ws] = it.val;
			CMD_SOLVE, CMD_WARM: begin
				ok = ($unsigned(row_m[rb+W_BODY_A]) < NBODY)
					&& ($unsigned(row_m[rb+W_BODY_B]) < NBODY);
				a = ok ? int'(row_m[rb+W_BODY_A]) : 0;
				b = ok ? int'(row_m[rb+W_BODY_B]) : 0;
				old = row_m[rb+W_IMP];
				if (it.cmd == CMD_WARM) begin
					if (ok) push_row(rb, a, b, old);
				end else if (!ok) begin
					res = row_m[rb+W_IMP];
				end else begin
					jv = sat(row_dot(rb, W_LIN_A, W_ANG_A, a) + row_dot(rb, W_LIN_B, W_ANG_B, b));
					bias = sat(mulq(bias_q, row_m[rb+W_ERR]));
					m = sat(mulq(row_m[rb+W_EFFM], mscale_q));
					s = sat(jv + bias);
					lambda = sat(-mulq(m, s) - mulq(iscale_q, old));
					nw = sat(old + lambda);
					// Lower limit first, so inverted limits end at the upper one.
					if (nw < longint'(row_m[rb+W_LOWER])) nw = row_m[rb+W_LOWER];
					if (nw > longint'(row_m[rb+W_UPPER])) nw = row_m[rb+W_UPPER];
					row_m[rb+W_IMP] = 32'(nw);
					push_row(rb, a, b, sat(nw - old));
					res = 32'(nw);
				end
			end
			CMD_RD_VEL: if (it.idx < NBODY && it.ws < VEL_WORDS)
				res = vel_m[it.idx*VEL_WORDS+it.ws];
			CMD_RD_ROW: if (it.ws < ROW_WORDS)
				res = row_m[rb+it.ws];
			default: ;
		endcase
	endtask

	// Driver: a beat holds while stalled; a fresh one is taken from the
	// pending queue with random gaps unless the no-idle stretch is on.
	always @(posedge clk or negedge arst_n) begin
		logic signed [31:0] r;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd <= '0;
			index <= '0;
			word_select <= '0;
			value <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_beat(cur, r);
				expected_data.insert(expected_data.size(), r);
				beats_taken++;
				if (cur.cmd == CMD_SOLVE) solves_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (pending.size() > 0 && (no_idle || $urandom_range(99) >= 20)) begin
					cur = pending.pop_front();
					cmd <= cur.cmd;
					index <= cur.idx;
					word_select <= cur.ws;
					value <= cur.val;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: each output beat is checked against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		logic signed [31:0] want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_data.size() == 0) begin
					errors++;
					$display("%0t: unexpected output beat, data %0d", $realtime, data);
				end else begin
					want = expected_data.pop_front();
					if (data !== want) begin
						errors++;
						$display("%0t: data mismatch, expected %0d actual %0d",
							$realtime, want, data);
					end
				end
			end
			out_stall <= !no_idle && ($urandom_range(99) < 20);
		end
	end

	function automatic void add(input logic [2:0] c, input int i, input int w,
			input logic signed [31:0] v);
		beat_t it;
		it.cmd = c;
		it.idx = 8'(i);
		it.ws = 5'(w);
		it.val = v;
		pending.insert(pending.size(), it);
	endfunction

	// The working set: bodies 0..7 and 63, rows 0..15 and 255. Only these are
	// ever read, so no read touches a word that was never written.
	function automatic int pick_body();
		return ($urandom_range(9) == 0) ? 63 : $urandom_range(7);
	endfunction

	function automatic int pick_row();
		return ($urandom_range(16) == 0) ? 255 : $urandom_range(15);
	endfunction

	function automatic logic signed [31:0] rand_q();
		case ($urandom_range(9))
			0: return $urandom;
			1: return ($urandom_range(1) == 1) ? 32'sh7FFFFFFF : 32'sh80000000;
			default: return $signed($urandom_range(524288)) - 32'sd262144;
		endcase
	endfunction

	function automatic logic signed [31:0] row_word(input int w);
		if (w == W_BODY_A || w == W_BODY_B) begin
			// Mostly a body of the working set; sometimes one out of range.
			if ($urandom_range(99) < 85) return pick_body();
			return ($urandom_range(1) == 1) ? $urandom_range(1000, 64) : $urandom | 32'h8000_0000;
		end
		if ((w == W_LOWER || w == W_UPPER) && $urandom_range(4) == 0)
			return (w == W_LOWER) ? 32'sh80000000 : 32'sh7FFFFFFF;
		return rand_q();
	endfunction

	function automatic void add_random(input int n);
		int r;
		int w;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 30) begin
				add(CMD_SOLVE, pick_row(), $urandom_range(31), $urandom);
			end else if (r < 40) begin
				add(CMD_WARM, pick_row(), $urandom_range(31), $urandom);
			end else if (r < 58) begin
				w = $urandom_range(20);
				add(CMD_WR_ROW, pick_row(), w, row_word(w));
			end else if (r < 66) begin
				add(CMD_WR_VEL, pick_body(), $urandom_range(5), rand_q());
			end else if (r < 72) begin
				add(CMD_WR_INR, pick_body(), $urandom_range(8), rand_q());
			end else if (r < 80) begin
				add(CMD_RD_VEL, pick_body(), $urandom_range(5), $urandom);
			end else if (r < 90) begin
				add(CMD_RD_ROW, pick_row(), $urandom_range(20), $urandom);
			end else begin
				// Noise: unknown command, bodies out of range, word selects past the record.
				case ($urandom_range(4))
					0: add(CMD_NONE, $urandom_range(255), $urandom_range(31), $urandom);
					1: add(3'($urandom_range(1)), $urandom_range(255, 64),
						$urandom_range(31), $urandom);
					2: add(CMD_RD_VEL, $urandom_range(255, 64), $urandom_range(31), $urandom);
					3: add(($urandom_range(1) == 1) ? CMD_WR_ROW : CMD_RD_ROW, pick_row(),
						$urandom_range(31, 21), $urandom);
					default: add(($urandom_range(1) == 1) ? CMD_WR_VEL : CMD_RD_VEL,
						pick_body(), $urandom_range(31, 6), $urandom);
				endcase
			end
		end
	endfunction

	// Waits until the sender has nothing left and every result is back.
	task automatic drain();
		while (pending.size() > 0 || in_valid || expected_data.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// APB write with a setup and an access phase; the register takes pwdata at the access edge.
	task automatic reg_write(input logic [3:0] addr, input logic [31:0] wd);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= wd;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr)
			REG_BIAS_RATE: bias_q = wd & 32'h7FFF_FFFF;
			REG_MASS_SCALE: mscale_q = wd & 32'h1_FFFF;
			default: iscale_q = wd & 32'h1_FFFF;
		endcase
	endtask

	task automatic run_setting(input logic [31:0] br, input logic [31:0] ms,
			input logic [31:0] is, input int n);
		drain();
		reg_write(REG_BIAS_RATE, br);
		reg_write(REG_MASS_SCALE, ms);
		reg_write(REG_IMPULSE_SCALE, is);
		add_random(n);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		no_idle = 1'b0;
		errors = 0;
		beats_taken = 0;
		solves_taken = 0;
		results_seen = 0;
		bias_q = 0;
		mscale_q = 65536;
		iscale_q = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset configuration: field extremes, ignored
		// writes, zero reads, the unknown command and an inert row.
		add(CMD_WR_VEL, 0, 0, 32'sh7FFFFFFF);
		add(CMD_WR_VEL, 63, 5, 32'sh80000000);
		add(CMD_RD_VEL, 0, 0, '0);
		add(CMD_RD_VEL, 63, 5, '1);
		add(CMD_WR_VEL, 64, 0, 32'sd1);
		add(CMD_WR_VEL, 255, 31, '1);
		add(CMD_RD_VEL, 200, 2, '0);
		add(CMD_RD_VEL, 0, 6, '0);
		add(CMD_WR_INR, 63, 8, 32'sh00010000);
		add(CMD_WR_INR, 0, 9, '1);
		add(CMD_WR_INR, 128, 0, '1);
		add(CMD_WR_ROW, 255, 20, 32'sd12345);
		add(CMD_RD_ROW, 255, 20, '0);
		add(CMD_WR_ROW, 255, 21, '1);
		add(CMD_RD_ROW, 255, 31, '0);
		add(CMD_NONE, 255, 31, '1);
		add(CMD_NONE, 0, 0, '0);
		// Row 255 points at a body out of range, so it stays inert.
		add(CMD_WR_ROW, 255, W_BODY_A, '1);
		add(CMD_WR_ROW, 255, W_BODY_B, 32'sd3);
		add(CMD_SOLVE, 255, 0, '0);
		add(CMD_WARM, 255, 0, '0);
		add(CMD_RD_ROW, 255, W_BODY_A, '0);

		// Load the whole working set so that solves read only defined words.
		for (int b = 0; b < 9; b++) begin
			for (int w = 0; w < VEL_WORDS; w++) add(CMD_WR_VEL, (b == 8) ? 63 : b, w, rand_q());
			for (int w = 0; w < INR_WORDS; w++) add(CMD_WR_INR, (b == 8) ? 63 : b, w, rand_q());
		end
		for (int r = 0; r < 17; r++)
			for (int w = 0; w < ROW_WORDS; w++)
				add(CMD_WR_ROW, (r == 16) ? 255 : r, w, row_word(w));

		// Random phases across configurations. Each drain before a register
		// write also makes the sender wait for every outstanding result.
		add_random(250);
		run_setting(32'h7FFF_FFFF, 32'd0, 32'd65536, 200);
		drain();
		no_idle = 1'b1;
		add_random(200);
		drain();
		no_idle = 1'b0;
		run_setting(32'd13107, 32'd52429, 32'd6554, 250);
		run_setting($urandom, $urandom_range(65536), $urandom_range(65536), 250);
		run_setting(32'd0, 32'd65536, 32'd0, 90);
		drain();

		$display("Covered %0d input beats (%0d solves), %0d results, over five settings",
			beats_taken, solves_taken, results_seen);
		$display("including saturating limits, inert rows and out-of-range accesses.");
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog: well beyond the slowest correct run.
	initial begin
		#30ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

[soft_constraint_impulse_solver_top.f]
sv/scis_pkg.sv
sv/scis_ram.sv
sv/scis_ctrl.sv
sv/scis_dp.sv
sv/soft_constraint_impulse_solver_top.sv
tb/testbench.sv
